FILE: hdl/ctsf_pkg.sv
// ----------------------------------------------------------------------------
// Cartesian to spherical field package
// Shared widths, stage counts, payload structures and the saturation helper.
// ----------------------------------------------------------------------------
package ctsf_pkg;

  localparam int DATA_W       = 32;
  localparam int FRAC_BITS    = 16;
  localparam int PROD_W       = 2 * DATA_W;
  localparam int WIDE_W       = PROD_W + DATA_W;
  localparam int SD_W         = 2;
  localparam int FRONT_STAGES = 4;
  localparam int ROOT_STAGES  = PROD_W / 2;
  localparam int DIV_STAGES   = PROD_W;
  localparam int BACK_STAGES  = 4;
  localparam int PIPE_DEPTH   = FRONT_STAGES + ROOT_STAGES + DIV_STAGES + BACK_STAGES;

  localparam logic [SD_W-1:0] SPACE_3D = 2'd3;

  localparam logic [WIDE_W-1:0] POS_LIM = {{(WIDE_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
  localparam logic [WIDE_W-1:0] NEG_LIM = POS_LIM + WIDE_W'(1);
  localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_AXIS   = 2'd1,
    ST_ORIGIN = 2'd2,
    ST_SAT    = 2'd3
  } status_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] pos_x;
    logic signed [DATA_W-1:0] pos_y;
    logic signed [DATA_W-1:0] pos_z;
    logic signed [DATA_W-1:0] grad_x;
    logic signed [DATA_W-1:0] grad_y;
    logic signed [DATA_W-1:0] grad_z;
  } point_t;

  // One step of the digit-by-digit square root.
  typedef struct packed {
    logic [DATA_W:0]   rem;
    logic [DATA_W-1:0] root;
    logic [PROD_W-1:0] rad;
  } sqrt_t;

  // One step of restoring division; quo shifts the dividend out and the quotient in.
  typedef struct packed {
    logic [DATA_W-1:0] rem;
    logic [PROD_W-1:0] quo;
    logic [DATA_W-1:0] dvs;
  } div_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] field_x;
    logic signed [DATA_W-1:0] field_y;
    logic signed [DATA_W-1:0] field_z;
    logic signed [DATA_W-1:0] z;
    logic                     num_neg;
    logic                     pxy_neg;
    logic signed [DATA_W-1:0] azi;
    logic                     azi_sat;
  } carry_t;

  typedef struct packed {
    carry_t            c;
    logic [PROD_W-1:0] num_mag;
    logic [PROD_W-1:0] pxy_mag;
  } sq_side_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] val;
    logic                     sat;
  } sat_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] field_x;
    logic signed [DATA_W-1:0] field_y;
    logic signed [DATA_W-1:0] field_z;
    logic signed [DATA_W-1:0] field_radial;
    logic signed [DATA_W-1:0] field_azimuth;
    logic signed [DATA_W-1:0] field_polar;
    status_e                  status;
  } result_t;

  // Clamps a sign and magnitude pair to the signed output range.
  function automatic sat_t sat32(input logic neg, input logic [WIDE_W-1:0] mag);
    sat_t res;
    res.sat = 1'b0;
    if (neg) begin
      if (mag > NEG_LIM) begin
        res.val = SAT_MIN;
        res.sat = 1'b1;
      end else begin
        res.val = -$signed(mag[DATA_W-1:0]);
      end
    end else begin
      if (mag > POS_LIM) begin
        res.val = SAT_MAX;
        res.sat = 1'b1;
      end else begin
        res.val = $signed(mag[DATA_W-1:0]);
      end
    end
    return res;
  endfunction

endpackage

FILE: hdl/ctsf_if.sv
// ----------------------------------------------------------------------------
// Cartesian to spherical field channels
// Valid/ready interfaces for the point input and the field result.
// ----------------------------------------------------------------------------
interface ctsf_in_if;
  import ctsf_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] pos_x;
  logic signed [DATA_W-1:0] pos_y;
  logic signed [DATA_W-1:0] pos_z;
  logic signed [DATA_W-1:0] grad_x;
  logic signed [DATA_W-1:0] grad_y;
  logic signed [DATA_W-1:0] grad_z;

  modport source (output valid, pos_x, pos_y, pos_z, grad_x, grad_y, grad_z, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, grad_x, grad_y, grad_z, output ready);
endinterface

interface ctsf_out_if;
  import ctsf_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] field_x;
  logic signed [DATA_W-1:0] field_y;
  logic signed [DATA_W-1:0] field_z;
  logic signed [DATA_W-1:0] field_radial;
  logic signed [DATA_W-1:0] field_azimuth;
  logic signed [DATA_W-1:0] field_polar;
  logic [1:0]               status;

  modport source (output valid, field_x, field_y, field_z, field_radial, field_azimuth,
                  field_polar, status, input ready);
  modport sink (input valid, field_x, field_y, field_z, field_radial, field_azimuth,
                field_polar, status, output ready);
endinterface

FILE: hdl/cartesian_to_spherical_field.sv
// ----------------------------------------------------------------------------
// Cartesian to spherical field
// Pipelined conversion of a gradient at a point into spherical components.
// ----------------------------------------------------------------------------
//  channel      | kind          | contents
//  pnt_i        | valid/ready   | position and gradient of one point
//  fld_o        | valid/ready   | Cartesian and spherical fields, status
//  space_dim*_i | write enable  | space dimension register, 3 is 3D
//
// One transaction enters per cycle unless the output holds an untaken result; each passes
// through 4 front stages, 32 square-root cells, 64 divide cells and 4 back stages.
// Reset clears the valid line and sets the space dimension to 3D.
// The whole pipeline stalls together while the output holds an untaken result.
module cartesian_to_spherical_field (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      space_dimension_we_i,
  input  logic [ctsf_pkg::SD_W-1:0] space_dimension_i,
  ctsf_in_if.sink                   pnt_i,
  ctsf_out_if.source                fld_o
);
  import ctsf_pkg::*;

  logic [SD_W-1:0]       sd_q;
  logic [PIPE_DEPTH-1:0] vld_q;
  logic                  adv;
  point_t                pnt;
  sq_side_t              front_side;
  logic [PROD_W-1:0]     s3_w, sxy_w;
  sqrt_t                 r_in, rxy_in;
  sqrt_t                 r_q   [ROOT_STAGES];
  sqrt_t                 rxy_q [ROOT_STAGES];
  sq_side_t              side_q [ROOT_STAGES];
  div_t                  dr_in, dx_in;
  div_t                  dr_q [DIV_STAGES];
  div_t                  dx_q [DIV_STAGES];
  carry_t                carry_q [DIV_STAGES];
  result_t               res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sd_q <= SPACE_3D;
    end else if (space_dimension_we_i) begin
      sd_q <= space_dimension_i;
    end
  end

  assign adv         = !vld_q[PIPE_DEPTH-1] || fld_o.ready;
  assign pnt_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[PIPE_DEPTH-2:0], pnt_i.valid};
    end
  end

  assign pnt.pos_x  = pnt_i.pos_x;
  assign pnt.pos_y  = pnt_i.pos_y;
  assign pnt.pos_z  = pnt_i.pos_z;
  assign pnt.grad_x = pnt_i.grad_x;
  assign pnt.grad_y = pnt_i.grad_y;
  assign pnt.grad_z = pnt_i.grad_z;

  ctsf_front u_front (
    .clk_i   (clk_i),
    .en_i    (adv),
    .three_i (sd_q == SPACE_3D),
    .pnt_i   (pnt),
    .side_o  (front_side),
    .s3_o    (s3_w),
    .sxy_o   (sxy_w)
  );

  always_comb begin
    r_in       = '0;
    r_in.rad   = s3_w;
    rxy_in     = '0;
    rxy_in.rad = sxy_w;
  end

  for (genvar i = 0; i < ROOT_STAGES; i++) begin : g_root
    if (i == 0) begin : g_first
      ctsf_sqrt_cell u_r   (.clk_i(clk_i), .en_i(adv), .d_i(r_in),   .q_o(r_q[i]));
      ctsf_sqrt_cell u_rxy (.clk_i(clk_i), .en_i(adv), .d_i(rxy_in), .q_o(rxy_q[i]));
      always_ff @(posedge clk_i) begin
        if (adv) begin
          side_q[i] <= front_side;
        end
      end
    end else begin : g_next
      ctsf_sqrt_cell u_r   (.clk_i(clk_i), .en_i(adv), .d_i(r_q[i-1]),   .q_o(r_q[i]));
      ctsf_sqrt_cell u_rxy (.clk_i(clk_i), .en_i(adv), .d_i(rxy_q[i-1]), .q_o(rxy_q[i]));
      always_ff @(posedge clk_i) begin
        if (adv) begin
          side_q[i] <= side_q[i-1];
        end
      end
    end
  end

  always_comb begin
    dr_in.rem = '0;
    dr_in.quo = side_q[ROOT_STAGES-1].num_mag;
    dr_in.dvs = r_q[ROOT_STAGES-1].root;
    dx_in.rem = '0;
    dx_in.quo = side_q[ROOT_STAGES-1].pxy_mag;
    dx_in.dvs = rxy_q[ROOT_STAGES-1].root;
  end

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
    if (j == 0) begin : g_first
      ctsf_div_cell u_rad (.clk_i(clk_i), .en_i(adv), .d_i(dr_in), .q_o(dr_q[j]));
      ctsf_div_cell u_pxy (.clk_i(clk_i), .en_i(adv), .d_i(dx_in), .q_o(dx_q[j]));
      always_ff @(posedge clk_i) begin
        if (adv) begin
          carry_q[j] <= side_q[ROOT_STAGES-1].c;
        end
      end
    end else begin : g_next
      ctsf_div_cell u_rad (.clk_i(clk_i), .en_i(adv), .d_i(dr_q[j-1]), .q_o(dr_q[j]));
      ctsf_div_cell u_pxy (.clk_i(clk_i), .en_i(adv), .d_i(dx_q[j-1]), .q_o(dx_q[j]));
      always_ff @(posedge clk_i) begin
        if (adv) begin
          carry_q[j] <= carry_q[j-1];
        end
      end
    end
  end

  ctsf_back u_back (
    .clk_i   (clk_i),
    .en_i    (adv),
    .c_i     (carry_q[DIV_STAGES-1]),
    .q_rad_i (dr_q[DIV_STAGES-1].quo),
    .t_i     (dx_q[DIV_STAGES-1].quo),
    .r_i     (dr_q[DIV_STAGES-1].dvs),
    .rxy_i   (dx_q[DIV_STAGES-1].dvs),
    .res_o   (res)
  );

  assign fld_o.valid         = vld_q[PIPE_DEPTH-1];
  assign fld_o.field_x       = res.field_x;
  assign fld_o.field_y       = res.field_y;
  assign fld_o.field_z       = res.field_z;
  assign fld_o.field_radial  = res.field_radial;
  assign fld_o.field_azimuth = res.field_azimuth;
  assign fld_o.field_polar   = res.field_polar;
  assign fld_o.status        = res.status;

`ifndef SYNTHESIS
  a_origin_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fld_o.valid && fld_o.status == ST_ORIGIN |->
      fld_o.field_radial == '0 && fld_o.field_azimuth == '0 && fld_o.field_polar == '0)
    else $error("origin transaction carries a nonzero spherical component");

  a_axis_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fld_o.valid && fld_o.status == ST_AXIS |->
      fld_o.field_polar == '0 && fld_o.field_azimuth == '0)
    else $error("on-axis transaction carries a nonzero polar or azimuth term");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pnt_i.ready |-> fld_o.valid && !fld_o.ready)
    else $error("input stalled without a blocked output transaction");
`endif

endmodule

FILE: hdl/ctsf_front.sv
// ----------------------------------------------------------------------------
// Cartesian to spherical field front end
// Products, dot sums, sums of squares and the azimuth term over four stages.
// ----------------------------------------------------------------------------
module ctsf_front (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic              three_i,
  input  ctsf_pkg::point_t  pnt_i,
  output ctsf_pkg::sq_side_t side_o,
  output logic [ctsf_pkg::PROD_W-1:0] s3_o,
  output logic [ctsf_pkg::PROD_W-1:0] sxy_o
);
  import ctsf_pkg::*;

  typedef struct packed {
    logic signed [DATA_W-1:0] fx, fy, fz, z;
    logic signed [PROD_W-1:0] sq_x, sq_y, sq_z;
    logic signed [PROD_W-1:0] p_xbx, p_yby, p_zbz, p_xby, p_ybx;
  } s1_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] fx, fy, fz, z;
    logic [PROD_W-1:0]        sxy, sq_z;
    logic signed [PROD_W-1:0] p_zbz;
    logic signed [PROD_W:0]   pxy, azi;
  } s2_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] fx, fy, fz, z;
    logic [PROD_W-1:0]        sxy, s3;
    logic signed [PROD_W:0]   pxy, azi;
    logic signed [PROD_W+1:0] num;
  } s3_t;

  s1_t s1_d, s1_q;
  s2_t s2_d, s2_q;
  s3_t s3_d, s3_q;
  sq_side_t side_d, side_q;
  logic [PROD_W-1:0] s3_out_q, sxy_out_q;

  logic signed [DATA_W-1:0] z_eff, bz_eff;
  logic signed [PROD_W+1:0] num_abs;
  logic signed [PROD_W:0]   pxy_abs, azi_abs;
  sat_t azi_res;

  // Any space dimension other than 3D takes z and its gradient as zero.
  assign z_eff  = three_i ? pnt_i.pos_z : '0;
  assign bz_eff = three_i ? pnt_i.grad_z : '0;

  always_comb begin
    s1_d.fx    = pnt_i.grad_x;
    s1_d.fy    = pnt_i.grad_y;
    s1_d.fz    = bz_eff;
    s1_d.z     = z_eff;
    s1_d.sq_x  = PROD_W'(pnt_i.pos_x * pnt_i.pos_x);
    s1_d.sq_y  = PROD_W'(pnt_i.pos_y * pnt_i.pos_y);
    s1_d.sq_z  = PROD_W'(z_eff * z_eff);
    s1_d.p_xbx = PROD_W'(pnt_i.pos_x * pnt_i.grad_x);
    s1_d.p_yby = PROD_W'(pnt_i.pos_y * pnt_i.grad_y);
    s1_d.p_zbz = PROD_W'(z_eff * bz_eff);
    s1_d.p_xby = PROD_W'(pnt_i.pos_x * pnt_i.grad_y);
    s1_d.p_ybx = PROD_W'(pnt_i.pos_y * pnt_i.grad_x);
  end

  always_comb begin
    s2_d.fx    = s1_q.fx;
    s2_d.fy    = s1_q.fy;
    s2_d.fz    = s1_q.fz;
    s2_d.z     = s1_q.z;
    s2_d.sxy   = $unsigned(s1_q.sq_x) + $unsigned(s1_q.sq_y);
    s2_d.sq_z  = $unsigned(s1_q.sq_z);
    s2_d.p_zbz = s1_q.p_zbz;
    s2_d.pxy   = (PROD_W+1)'($signed(s1_q.p_xbx)) + (PROD_W+1)'($signed(s1_q.p_yby));
    s2_d.azi   = (PROD_W+1)'($signed(s1_q.p_xby)) - (PROD_W+1)'($signed(s1_q.p_ybx));
  end

  always_comb begin
    s3_d.fx  = s2_q.fx;
    s3_d.fy  = s2_q.fy;
    s3_d.fz  = s2_q.fz;
    s3_d.z   = s2_q.z;
    s3_d.sxy = s2_q.sxy;
    s3_d.s3  = s2_q.sxy + s2_q.sq_z;
    s3_d.pxy = s2_q.pxy;
    s3_d.azi = s2_q.azi;
    s3_d.num = (PROD_W+2)'($signed(s2_q.pxy)) + (PROD_W+2)'($signed(s2_q.p_zbz));
  end

  always_comb begin
    num_abs = s3_q.num[PROD_W+1] ? -s3_q.num : s3_q.num;
    pxy_abs = s3_q.pxy[PROD_W] ? -s3_q.pxy : s3_q.pxy;
    azi_abs = s3_q.azi[PROD_W] ? -s3_q.azi : s3_q.azi;
    // The azimuth term drops its fraction bits toward zero, then clamps.
    azi_res = sat32(s3_q.azi[PROD_W], WIDE_W'(azi_abs[PROD_W-1:0] >> FRAC_BITS));
    side_d.c.field_x = s3_q.fx;
    side_d.c.field_y = s3_q.fy;
    side_d.c.field_z = s3_q.fz;
    side_d.c.z       = s3_q.z;
    side_d.c.num_neg = s3_q.num[PROD_W+1];
    side_d.c.pxy_neg = s3_q.pxy[PROD_W];
    side_d.c.azi     = azi_res.val;
    side_d.c.azi_sat = azi_res.sat;
    side_d.num_mag   = num_abs[PROD_W-1:0];
    side_d.pxy_mag   = pxy_abs[PROD_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q      <= s1_d;
      s2_q      <= s2_d;
      s3_q      <= s3_d;
      side_q    <= side_d;
      s3_out_q  <= s3_q.s3;
      sxy_out_q <= s3_q.sxy;
    end
  end

  assign side_o = side_q;
  assign s3_o   = s3_out_q;
  assign sxy_o  = sxy_out_q;

endmodule

FILE: hdl/ctsf_sqrt_cell.sv
// ----------------------------------------------------------------------------
// Cartesian to spherical field root cell
// One result bit of an integer square root, two radicand bits per cell.
// ----------------------------------------------------------------------------
module ctsf_sqrt_cell (
  input  logic             clk_i,
  input  logic             en_i,
  input  ctsf_pkg::sqrt_t  d_i,
  output ctsf_pkg::sqrt_t  q_o
);
  import ctsf_pkg::*;

  sqrt_t             step_d, step_q;
  logic [DATA_W+2:0] rem_sh, trial, diff;
  logic              ge;

  always_comb begin
    rem_sh = {d_i.rem, d_i.rad[PROD_W-1 -: 2]};
    trial  = {1'b0, d_i.root, 2'b01};
    diff   = rem_sh - trial;
    ge     = rem_sh >= trial;
    step_d.rem  = ge ? diff[DATA_W:0] : rem_sh[DATA_W:0];
    step_d.root = {d_i.root[DATA_W-2:0], ge};
    step_d.rad  = {d_i.rad[PROD_W-3:0], 2'b00};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      step_q <= step_d;
    end
  end

  assign q_o = step_q;

endmodule

FILE: hdl/ctsf_div_cell.sv
// ----------------------------------------------------------------------------
// Cartesian to spherical field divide cell
// One quotient bit of a restoring division, divisor carried along.
// ----------------------------------------------------------------------------
module ctsf_div_cell (
  input  logic            clk_i,
  input  logic            en_i,
  input  ctsf_pkg::div_t  d_i,
  output ctsf_pkg::div_t  q_o
);
  import ctsf_pkg::*;

  div_t            step_d, step_q;
  logic [DATA_W:0] rem_sh, diff;
  logic            ge;

  always_comb begin
    rem_sh = {d_i.rem, d_i.quo[PROD_W-1]};
    diff   = rem_sh - {1'b0, d_i.dvs};
    ge     = rem_sh >= {1'b0, d_i.dvs};
    step_d.rem = ge ? diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
    step_d.quo = {d_i.quo[PROD_W-2:0], ge};
    step_d.dvs = d_i.dvs;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      step_q <= step_d;
    end
  end

  assign q_o = step_q;

endmodule

FILE: hdl/ctsf_back.sv
// ----------------------------------------------------------------------------
// Cartesian to spherical field back end
// Radial clamp, polar products and sum, status and the output register.
// ----------------------------------------------------------------------------
module ctsf_back (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  ctsf_pkg::carry_t            c_i,
  input  logic [ctsf_pkg::PROD_W-1:0] q_rad_i,
  input  logic [ctsf_pkg::PROD_W-1:0] t_i,
  input  logic [ctsf_pkg::DATA_W-1:0] r_i,
  input  logic [ctsf_pkg::DATA_W-1:0] rxy_i,
  output ctsf_pkg::result_t           res_o
);
  import ctsf_pkg::*;

  typedef struct packed {
    carry_t            c;
    sat_t              rad;
    logic              r_zero, rxy_zero, zt_neg;
    logic [PROD_W-1:0] zt_lo, zt_hi, rvbz;
  } b1_t;

  typedef struct packed {
    carry_t            c;
    sat_t              rad;
    logic              r_zero, rxy_zero, zt_neg;
    logic [WIDE_W-1:0] zt_mag;
    logic [PROD_W-1:0] rvbz;
  } b2_t;

  typedef struct packed {
    carry_t            c;
    sat_t              rad;
    logic              r_zero, rxy_zero, p_neg;
    logic [WIDE_W-1:0] p_mag;
  } b3_t;

  b1_t b1_d, b1_q;
  b2_t b2_d, b2_q;
  b3_t b3_d, b3_q;
  result_t res_d, res_q;

  logic [DATA_W-1:0] z_mag, bz_mag;
  logic [WIDE_W-1:0] rv_w;
  logic              rv_neg;
  sat_t              pol;

  always_comb begin
    z_mag  = c_i.z[DATA_W-1] ? -c_i.z : c_i.z;
    bz_mag = c_i.field_z[DATA_W-1] ? -c_i.field_z : c_i.field_z;
    b1_d.c        = c_i;
    b1_d.rad      = sat32(c_i.num_neg, WIDE_W'(q_rad_i));
    b1_d.r_zero   = (r_i == '0);
    b1_d.rxy_zero = (rxy_i == '0);
    b1_d.zt_neg   = c_i.z[DATA_W-1] ^ c_i.pxy_neg;
    // z times the 64-bit quotient as two 32 by 32 partial products.
    b1_d.zt_lo    = PROD_W'(z_mag * t_i[DATA_W-1:0]);
    b1_d.zt_hi    = PROD_W'(z_mag * t_i[PROD_W-1:DATA_W]);
    b1_d.rvbz     = PROD_W'(rxy_i * bz_mag);
  end

  always_comb begin
    b2_d.c        = b1_q.c;
    b2_d.rad      = b1_q.rad;
    b2_d.r_zero   = b1_q.r_zero;
    b2_d.rxy_zero = b1_q.rxy_zero;
    b2_d.zt_neg   = b1_q.zt_neg;
    b2_d.zt_mag   = (WIDE_W'(b1_q.zt_hi) << DATA_W) + WIDE_W'(b1_q.zt_lo);
    b2_d.rvbz     = b1_q.rvbz;
  end

  // Sign and magnitude sum of z*t and -(rxy*bz).
  always_comb begin
    rv_w   = WIDE_W'(b2_q.rvbz);
    rv_neg = !b2_q.c.field_z[DATA_W-1];
    b3_d.c        = b2_q.c;
    b3_d.rad      = b2_q.rad;
    b3_d.r_zero   = b2_q.r_zero;
    b3_d.rxy_zero = b2_q.rxy_zero;
    if (b2_q.zt_neg == rv_neg) begin
      b3_d.p_neg = rv_neg;
      b3_d.p_mag = b2_q.zt_mag + rv_w;
    end else if (b2_q.zt_mag >= rv_w) begin
      b3_d.p_neg = b2_q.zt_neg;
      b3_d.p_mag = b2_q.zt_mag - rv_w;
    end else begin
      b3_d.p_neg = rv_neg;
      b3_d.p_mag = rv_w - b2_q.zt_mag;
    end
  end

  always_comb begin
    pol = sat32(b3_q.p_neg, b3_q.p_mag >> FRAC_BITS);
    res_d.field_x = b3_q.c.field_x;
    res_d.field_y = b3_q.c.field_y;
    res_d.field_z = b3_q.c.field_z;
    if (b3_q.r_zero) begin
      res_d.field_radial  = '0;
      res_d.field_azimuth = '0;
      res_d.field_polar   = '0;
      res_d.status        = ST_ORIGIN;
    end else if (b3_q.rxy_zero) begin
      res_d.field_radial  = b3_q.rad.val;
      res_d.field_azimuth = b3_q.c.azi;
      res_d.field_polar   = '0;
      res_d.status        = ST_AXIS;
    end else begin
      res_d.field_radial  = b3_q.rad.val;
      res_d.field_azimuth = b3_q.c.azi;
      res_d.field_polar   = pol.val;
      res_d.status        = (b3_q.rad.sat || b3_q.c.azi_sat || pol.sat) ? ST_SAT : ST_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b1_q  <= b1_d;
      b2_q  <= b2_d;
      b3_q  <= b3_d;
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

FILE: tb/cartesian_to_spherical_field_tb.sv
// ----------------------------------------------------------------------------
// Cartesian to spherical field testbench
// Drives points through the valid/ready input, predicts the radial, azimuthal
// and polar fields with saturation and status, and checks every result in
// order. Covers both space modes, the origin and axis cases, full-range and
// small operands, random idling on both channels and a long output stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module cartesian_to_spherical_field_tb;
  import ctsf_pkg::*;

  typedef struct {
    bit        neg;
    bit [63:0] mag;
  } smag_t;

  logic                clk_i;
  logic                rst_ni;
  logic                space_dimension_we_i;
  logic [SD_W-1:0]     space_dimension_i;

  ctsf_in_if  pnt();
  ctsf_out_if fld();

  cartesian_to_spherical_field dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .space_dimension_we_i (space_dimension_we_i),
    .space_dimension_i    (space_dimension_i),
    .pnt_i                (pnt),
    .fld_o                (fld)
  );

  result_t         field_queue[$];
  logic [SD_W-1:0] model_dim;
  bit              clamp_seen;
  bit              quiet;
  int              hold_cycles;
  int              error_count;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #10ms;
    $display("cartesian_to_spherical_field test failed");
    $finish;
  end

  // ---------------------------------------------------------------- predictor
  function automatic smag_t to_smag(logic [31:0] raw);
    smag_t v;
    v.neg = raw[31];
    v.mag = raw[31] ? 64'(33'h1_0000_0000 - {1'b0, raw}) : 64'(raw);
    return v;
  endfunction

  function automatic smag_t smul(smag_t a, smag_t b);
    smag_t v;
    logic [127:0] full;
    full = 128'(a.mag) * 128'(b.mag);
    if (full[127:64] != 0) begin
      v.mag = '1;
      clamp_seen = 1'b1;
    end else begin
      v.mag = full[63:0];
    end
    v.neg = (a.neg != b.neg) && v.mag != 0;
    return v;
  endfunction

  function automatic smag_t sneg(smag_t a);
    a.neg = !a.neg && a.mag != 0;
    return a;
  endfunction

  function automatic smag_t sadd(smag_t a, smag_t b);
    smag_t v;
    logic [64:0] s;
    if (a.neg == b.neg) begin
      v.neg = a.neg;
      s = {1'b0, a.mag} + {1'b0, b.mag};
      if (s[64]) begin
        v.mag = '1;
        clamp_seen = 1'b1;
      end else begin
        v.mag = s[63:0];
      end
    end else if (a.mag >= b.mag) begin
      v.neg = a.neg;
      v.mag = a.mag - b.mag;
    end else begin
      v.neg = b.neg;
      v.mag = b.mag - a.mag;
    end
    if (v.mag == 0) v.neg = 1'b0;
    return v;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitpos;
    res = 0;
    bitpos = 64'd1 << 62;
    while (bitpos > v) bitpos = bitpos >> 2;
    while (bitpos != 0) begin
      if (v >= res + bitpos) begin
        v = v - (res + bitpos);
        res = (res >> 1) + bitpos;
      end else begin
        res = res >> 1;
      end
      bitpos = bitpos >> 2;
    end
    return res;
  endfunction

  function automatic logic [31:0] clamp32(smag_t v);
    if (v.neg) begin
      if (v.mag > 64'h8000_0000) begin
        clamp_seen = 1'b1;
        return 32'h8000_0000;
      end
      return 32'(64'h1_0000_0000 - v.mag);
    end
    if (v.mag > 64'h7FFF_FFFF) begin
      clamp_seen = 1'b1;
      return 32'h7FFF_FFFF;
    end
    return v.mag[31:0];
  endfunction

  function automatic result_t predict_field(point_t p);
    result_t res;
    bit      full3d;
    smag_t   x, y, z, bx, by, bz, pxy, num, q, a, t, pr, rv, zero_v;
    logic [63:0] sxy, rad_r, rxy;
    full3d = (model_dim == SPACE_3D);
    zero_v.neg = 1'b0;
    zero_v.mag = 64'd0;
    x  = to_smag(p.pos_x);
    y  = to_smag(p.pos_y);
    z  = full3d ? to_smag(p.pos_z) : zero_v;
    bx = to_smag(p.grad_x);
    by = to_smag(p.grad_y);
    bz = full3d ? to_smag(p.grad_z) : zero_v;
    clamp_seen = 1'b0;
    res.field_x = p.grad_x;
    res.field_y = p.grad_y;
    res.field_z = full3d ? p.grad_z : '0;
    res.field_radial = '0;
    res.field_azimuth = '0;
    res.field_polar = '0;
    // The 64-bit sum of squares cannot wrap, even in 3D; the hardware root sees the same sum.
    sxy = x.mag * x.mag + y.mag * y.mag;
    rad_r = int_sqrt(sxy + z.mag * z.mag);
    rxy = int_sqrt(sxy);
    if (rad_r == 0) begin
      res.status = ST_ORIGIN;
    end else begin
      pxy = sadd(smul(x, bx), smul(y, by));
      num = sadd(pxy, smul(z, bz));
      q.neg = num.neg;
      q.mag = num.mag / rad_r;
      if (q.mag == 0) q.neg = 1'b0;
      res.field_radial = clamp32(q);
      a = sadd(sneg(smul(y, bx)), smul(x, by));
      a.mag = a.mag >> FRAC_BITS;
      if (a.mag == 0) a.neg = 1'b0;
      res.field_azimuth = clamp32(a);
      if (rxy == 0) begin
        res.status = ST_AXIS;
      end else begin
        t.neg = pxy.neg;
        t.mag = pxy.mag / rxy;
        if (t.mag == 0) t.neg = 1'b0;
        rv.neg = 1'b0;
        rv.mag = rxy;
        pr = sadd(smul(z, t), sneg(smul(rv, bz)));
        pr.mag = pr.mag >> FRAC_BITS;
        if (pr.mag == 0) pr.neg = 1'b0;
        res.field_polar = clamp32(pr);
        res.status = clamp_seen ? ST_SAT : ST_OK;
      end
    end
    return res;
  endfunction

  // ---------------------------------------------------------------- checking
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: %s mismatch, got %h expected %h", $realtime, what, got, want);
    error_count++;
  endtask

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && fld.valid && fld.ready) begin
      if (field_queue.size() == 0) begin
        $display("%0t: result transaction with nothing expected", $realtime);
        error_count++;
      end else begin
        want = field_queue.pop_front();
        if (fld.field_x !== want.field_x) report_mismatch("field_x", fld.field_x, want.field_x);
        if (fld.field_y !== want.field_y) report_mismatch("field_y", fld.field_y, want.field_y);
        if (fld.field_z !== want.field_z) report_mismatch("field_z", fld.field_z, want.field_z);
        if (fld.field_radial !== want.field_radial)
          report_mismatch("field_radial", fld.field_radial, want.field_radial);
        if (fld.field_azimuth !== want.field_azimuth)
          report_mismatch("field_azimuth", fld.field_azimuth, want.field_azimuth);
        if (fld.field_polar !== want.field_polar)
          report_mismatch("field_polar", fld.field_polar, want.field_polar);
        if (fld.status !== want.status) report_mismatch("status", fld.status, want.status);
      end
    end
  end

  // Output side: random stall bursts, plus a long hold-off on request.
  initial begin
    int stall_left;
    stall_left = 0;
    fld.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        hold_cycles--;
        fld.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        fld.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 19) - 1;
        fld.ready <= 1'b0;
      end else begin
        fld.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  task automatic send_point(point_t p);
    if (!quiet && $urandom_range(0, 9) == 0) begin
      pnt.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end
    pnt.valid  <= 1'b1;
    pnt.pos_x  <= p.pos_x;
    pnt.pos_y  <= p.pos_y;
    pnt.pos_z  <= p.pos_z;
    pnt.grad_x <= p.grad_x;
    pnt.grad_y <= p.grad_y;
    pnt.grad_z <= p.grad_z;
    do @(posedge clk_i); while (!pnt.ready);
    field_queue.insert(field_queue.size(), predict_field(p));
    @(negedge clk_i);
  endtask

  task automatic end_burst();
    pnt.valid <= 1'b0;
  endtask

  task automatic set_space_dimension(logic [SD_W-1:0] dim);
    end_burst();
    while (field_queue.size() != 0) @(negedge clk_i);
    space_dimension_we_i <= 1'b1;
    space_dimension_i    <= dim;
    @(negedge clk_i);
    space_dimension_we_i <= 1'b0;
    model_dim = dim;
  endtask

  function automatic logic [31:0] small_value();
    return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
  endfunction

  function automatic point_t random_point();
    point_t p;
    int     kind;
    kind = $urandom_range(0, 9);
    p = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    if (kind < 5) begin
      p = '{small_value(), small_value(), small_value(),
            small_value(), small_value(), small_value()};
    end else if (kind == 5) begin
      p.pos_x = small_value() >>> $urandom_range(0, 20);
      p.pos_y = small_value() >>> $urandom_range(0, 20);
    end
    if (kind == 6) begin
      p.pos_x = '0;
      p.pos_y = '0;
    end
    if (kind == 7 && $urandom_range(0, 3) == 0) begin
      p.pos_x = '0;
      p.pos_y = '0;
      p.pos_z = '0;
    end
    return p;
  endfunction

  task automatic test_directed();
    point_t list[15];
    list[0]  = '{32'sh0, 32'sh0, 32'sh0, 32'sh1_0000, 32'sh2_0000, 32'sh3_0000};
    list[1]  = '{32'sh0, 32'sh0, 32'sh2_0000, 32'sh1_0000, 32'sh1_0000, 32'sh1_0000};
    list[2]  = '{32'sh0, 32'sh0, -32'sh2_0000, -32'sh1_0000, 32'sh5, -32'sh1_0000};
    list[3]  = '{32'sh1_0000, 32'sh0, 32'sh0, 32'sh1_0000, 32'sh0, 32'sh0};
    list[4]  = '{32'sh3_0000, 32'sh4_0000, 32'sh0, 32'sh1_0000, 32'sh1_0000, 32'sh0};
    list[5]  = '{32'sh1_0000, 32'sh1_0000, 32'sh1_0000, 32'sh1_0000, -32'sh1_0000, 32'sh2};
    list[6]  = '{SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX};
    list[7]  = '{SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN};
    list[8]  = '{SAT_MIN, SAT_MAX, SAT_MIN, SAT_MAX, SAT_MIN, SAT_MAX};
    list[9]  = '{32'sh1, 32'sh0, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MIN};
    list[10] = '{32'sh1, 32'sh1, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MAX};
    list[11] = '{-32'sh1, 32'sh0, 32'sh0, SAT_MIN, SAT_MAX, 32'sh0};
    list[12] = '{32'shFFFF, -32'sh1_0001, 32'sh7, -32'sh1, 32'sh1, -32'sh1};
    list[13] = '{32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0};
    list[14] = '{-32'sh1, -32'sh1, -32'sh1, -32'sh1, -32'sh1, -32'sh1};
    foreach (list[i]) send_point(list[i]);
    set_space_dimension(2'd2);
    foreach (list[i]) if (i < 8) send_point(list[i]);
    set_space_dimension(SPACE_3D);
  endtask

  task automatic test_random(int count);
    repeat (count) send_point(random_point());
  endtask

  task automatic test_dimension_sweep();
    for (int d = 0; d < 4; d++) begin
      set_space_dimension(SD_W'(d));
      test_random(150);
    end
    set_space_dimension(SPACE_3D);
  endtask

  task automatic test_output_hold();
    end_burst();
    @(negedge clk_i);
    hold_cycles = 3 * PIPE_DEPTH;
    test_random(250);
  endtask

  task automatic test_quiet_tail();
    quiet = 1'b1;
    test_random(200);
  endtask

  initial begin
    error_count = 0;
    quiet = 1'b0;
    hold_cycles = 0;
    model_dim = SPACE_3D;
    rst_ni = 1'b0;
    space_dimension_we_i = 1'b0;
    space_dimension_i = SPACE_3D;
    pnt.valid = 1'b0;
    pnt.pos_x = '0;
    pnt.pos_y = '0;
    pnt.pos_z = '0;
    pnt.grad_x = '0;
    pnt.grad_y = '0;
    pnt.grad_z = '0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_random(500);
    test_dimension_sweep();
    test_output_hold();
    test_quiet_tail();

    end_burst();
    while (field_queue.size() != 0) @(posedge clk_i);
    repeat (PIPE_DEPTH + 20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("cartesian_to_spherical_field test passed");
    end else begin
      $display("cartesian_to_spherical_field test failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/ctsf_pkg.sv
hdl/ctsf_if.sv
hdl/ctsf_front.sv
hdl/ctsf_sqrt_cell.sv
hdl/ctsf_div_cell.sv
hdl/ctsf_back.sv
hdl/cartesian_to_spherical_field.sv
tb/cartesian_to_spherical_field_tb.sv
